FILE: rtl/core/sevt_pkg.sv
// Shared sizes, types and command codes for the sorted event table.
// Used by sorted_event_table_top, the scoreboard and the testbench; depends on nothing else.
package sevt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 40;
   localparam int MASK_W      = 32;
   localparam int POS_W       = 7;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      key_type  key;
      mask_type mask;
   } entry_type;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

endpackage

FILE: rtl/core/sorted_event_table_top.sv
// Sorted event table: binary-search lookup and ordered insert over one RAM.
// Depends on sevt_pkg for sizes, the entry type and the command codes.
//
// Usage:
//   Input channel: drive req_* and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy is high from the
//   cycle after the transfer and is low again once the result is presented.
//   Result channel: rsp_valid is high for exactly one cycle with found,
//   position, notify mask and overflow; the receiver cannot stall it, so it
//   must take the result in that cycle.
//   Search: a search makes at most ceil(log2(entry count + 1)) probes,
//   each a RAM read and a compare, then a read of the final candidate and a
//   match step. The result is presented with busy low, so the next transfer
//   can be taken in the cycle in which the result is presented.
//   An insert of a new key also moves every higher entry up one slot through
//   the RAM, with a read and a write per moved entry, then writes the new one.
//   The search loop and the move loop share the one RAM read port.
//   Reset: the entry count goes to zero, so the table starts empty; the RAM
//   contents are not cleared, and an entry is never used before it is written.
module sorted_event_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [7:0]                    req_int_number,
   input  logic [15:0]                   req_function_code,
   input  logic [15:0]                   req_subfunction_code,
   input  logic [sevt_pkg::MASK_W-1:0]   req_notify_mask_in,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [sevt_pkg::POS_W-1:0]    rsp_position,
   output logic [sevt_pkg::MASK_W-1:0]   rsp_notify_mask_out,
   output logic                          rsp_overflow
);
   import sevt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_PROBE    = 6'b000010,
      S_CMP      = 6'b000100,
      S_MATCH    = 6'b001000,
      S_SHIFT_RD = 6'b010000,
      S_SHIFT_WR = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   lo_ff, lo_in;
   cnt_type   hi_ff, hi_in;
   cnt_type   idx_ff, idx_in;
   logic      rsp_valid_ff, rsp_valid_in;

   cmd_type   cmd_ff, cmd_in;
   key_type   key_ff, key_in;
   mask_type  mask_ff, mask_in;
   logic      rsp_found_ff, rsp_found_in;
   cnt_type   rsp_pos_ff, rsp_pos_in;
   mask_type  rsp_mask_ff, rsp_mask_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   entry_type entry_mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;
   idx_type   rd_addr;
   idx_type   wr_addr;
   entry_type wr_data;
   logic      mem_we;

   cnt_type   mid;
   logic      hit;
   logic      full;

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hit  = (lo_ff < count_ff) && (rd_data_ff.key == key_ff);
   assign full = (count_ff >= CNT_W'(TABLE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      mask_in      = mask_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_addr      = lo_ff[IDX_W-1:0];
      wr_addr      = lo_ff[IDX_W-1:0];
      wr_data      = rd_data_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(req_command);
               key_in   = {req_int_number, req_function_code, req_subfunction_code};
               mask_in  = req_notify_mask_in;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // Either read the midpoint of the open range, or the final
            // candidate once the range has closed.
            if (hi_ff > lo_ff) begin
               rd_addr  = mid[IDX_W-1:0];
               state_in = S_CMP;
            end else begin
               rd_addr  = lo_ff[IDX_W-1:0];
               state_in = S_MATCH;
            end
         end
         S_CMP: begin
            if (rd_data_ff.key < key_ff) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            state_in = S_PROBE;
         end
         S_MATCH: begin
            rsp_found_in = hit;
            rsp_pos_in   = lo_ff;
            rsp_mask_in  = hit ? rd_data_ff.mask : '0;
            rsp_ovf_in   = 1'b0;
            if (cmd_ff == CMD_LOOKUP) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (full) begin
               rsp_ovf_in   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (hit) begin
               mem_we       = 1'b1;
               wr_data.key  = key_ff;
               wr_data.mask = rd_data_ff.mask | mask_ff;
               rsp_mask_in  = rd_data_ff.mask | mask_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               idx_in   = count_ff;
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            // Move entries up from the top end down to the insertion point.
            if (idx_ff > lo_ff) begin
               rd_addr  = idx_type'(idx_ff - CNT_W'(1));
               state_in = S_SHIFT_WR;
            end else begin
               mem_we       = 1'b1;
               wr_data.key  = key_ff;
               wr_data.mask = mask_ff;
               count_in     = count_ff + CNT_W'(1);
               rsp_mask_in  = mask_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SHIFT_WR: begin
            mem_we   = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - CNT_W'(1);
            state_in = S_SHIFT_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      mask_ff      <= mask_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_position        = POS_W'(rsp_pos_ff);
   assign rsp_notify_mask_out = rsp_mask_ff;
   assign rsp_overflow        = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result presented while an operation is still running");

   a_ovf_only_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> full)
      else $error("overflow reported while the table has room");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ((lo_ff <= hi_ff) && (hi_ff <= count_ff)))
      else $error("binary search range out of order");
`endif

endmodule

FILE: sim/sevt_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted event table: a shadow copy of the table that predicts each
// response, plus the queue of predicted responses. Depends on sevt_pkg.
package sevt_scoreboard_pkg;
   import sevt_pkg::*;

   typedef struct {
      logic               found;
      logic [POS_W-1:0]   position;
      mask_type           notify_mask;
      logic               overflow;
   } event_response_type;

   class event_table_scoreboard_type;
      key_type            keys[TABLE_DEPTH];
      mask_type           masks[TABLE_DEPTH];
      int unsigned        entry_total;
      int unsigned        errors;
      event_response_type predicted[$];

      function new();
         entry_total = 0;
         errors = 0;
      endfunction

      // Binary search over the valid entries only, as the hardware does.
      function int unsigned first_not_below(key_type key);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = entry_total;
         while (hi > lo) begin
            mid = lo + ((hi - lo) >> 1);
            if (keys[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      // Called when a transfer is accepted: updates the shadow table and queues the
      // response it must produce.
      function void apply_command(cmd_type cmd, key_type key, mask_type mask_in);
         event_response_type r;
         int unsigned pos;
         logic hit;
         pos = first_not_below(key);
         hit = (pos < entry_total) && (keys[pos] == key);
         r.found = hit;
         r.position = POS_W'(pos);
         r.notify_mask = hit ? masks[pos] : '0;
         r.overflow = 1'b0;
         if (cmd == CMD_INSERT) begin
            if (entry_total >= TABLE_DEPTH) begin
               r.overflow = 1'b1;
            end else if (hit) begin
               masks[pos] = masks[pos] | mask_in;
               r.notify_mask = masks[pos];
            end else begin
               for (int unsigned i = entry_total; i > pos; i--) begin
                  keys[i] = keys[i-1];
                  masks[i] = masks[i-1];
               end
               keys[pos] = key;
               masks[pos] = mask_in;
               entry_total++;
               r.notify_mask = mask_in;
            end
         end
         predicted.push_back(r);
      endfunction

      function void check_response(logic found, logic [POS_W-1:0] position,
                                   mask_type notify_mask, logic overflow);
         event_response_type want;
         if (predicted.size() == 0) begin
            $display("%0t: response with none expected: found=%0b position=%0d",
                     $time, found, position);
            $display("%0t: mask=%h overflow=%0b", $time, notify_mask, overflow);
            errors++;
            return;
         end
         want = predicted.pop_front();
         if (found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found, found);
            errors++;
         end
         if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position, position);
            errors++;
         end
         if (notify_mask !== want.notify_mask) begin
            $display("%0t: notify mask expected %h actual %h",
                     $time, want.notify_mask, notify_mask);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, overflow);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return predicted.size();
      endfunction
   endclass

endpackage

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for sorted_event_table_top: directed and random lookups and inserts, checked
// against the scoreboard in sevt_scoreboard_pkg. Depends on sevt_pkg and that package.
module testbench;
   import sevt_pkg::*;
   import sevt_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS = 580;
   localparam int FILL_AT      = 380;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = 1'b0;
   logic [7:0]  req_int_number = '0;
   logic [15:0] req_function_code = '0;
   logic [15:0] req_subfunction_code = '0;
   mask_type    req_notify_mask_in = '0;
   logic        rsp_valid;
   logic        rsp_found;
   logic [POS_W-1:0] rsp_position;
   mask_type    rsp_notify_mask_out;
   logic        rsp_overflow;

   bit gaps_on = 1'b1;
   event_table_scoreboard_type table_model;

   sorted_event_table_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_int_number       (req_int_number),
      .req_function_code    (req_function_code),
      .req_subfunction_code (req_subfunction_code),
      .req_notify_mask_in   (req_notify_mask_in),
      .rsp_valid            (rsp_valid),
      .rsp_found            (rsp_found),
      .rsp_position         (rsp_position),
      .rsp_notify_mask_out  (rsp_notify_mask_out),
      .rsp_overflow         (rsp_overflow)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         table_model.check_response(rsp_found, rsp_position, rsp_notify_mask_out,
                                    rsp_overflow);
      end
   end

   // Holds the command on the ports until the transfer, then records it.
   task automatic send_command(input cmd_type cmd, input key_type key, input mask_type mask);
      req_command <= cmd;
      req_int_number <= key[39:32];
      req_function_code <= key[31:16];
      req_subfunction_code <= key[15:0];
      req_notify_mask_in <= mask;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      table_model.apply_command(cmd, key, mask);
   endtask

   task automatic maybe_pause();
      if (gaps_on && $urandom_range(99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      while (table_model.pending() != 0) @(posedge clock);
   endtask

   function automatic mask_type pick_mask();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return mask_type'(1) << $urandom_range(31);
         default: return $urandom();
      endcase
   endfunction

   // Half the keys are stored or sit right next to stored ones (all are random while the
   // table is empty), so that the search lands on hits, neighbors and every insertion point.
   function automatic key_type pick_key();
      key_type base;
      int unsigned choice;
      choice = $urandom_range(5);
      if (table_model.entry_total != 0) begin
         base = table_model.keys[$urandom_range(table_model.entry_total - 1)];
      end else begin
         base = '0;
         choice = 5;
      end
      case (choice)
         0, 1: return base;
         2: return $urandom_range(1) ? base + 1'b1 : base - 1'b1;
         3: begin
            case ($urandom_range(2))
               0: base[39:32] = 8'($urandom());
               1: base[31:16] = 16'($urandom());
               default: base[15:0] = 16'($urandom());
            endcase
            return base;
         end
         4: return {($urandom_range(1) ? 8'hff : 8'h00), ($urandom_range(1) ? 16'hffff : 16'h0),
                    ($urandom_range(1) ? 16'hffff : 16'h0)};
         default: return {8'($urandom()), 16'($urandom()), 16'($urandom())};
      endcase
   endfunction

   initial begin
      table_model = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, both ends of the key range, merges and misses.
      send_command(CMD_LOOKUP, 40'h00_0000_0000, '1);
      send_command(CMD_LOOKUP, 40'hff_ffff_ffff, '0);
      send_command(CMD_INSERT, 40'h80_1234_5678, 32'h0000_0001);
      send_command(CMD_INSERT, 40'hff_ffff_ffff, 32'hffff_ffff);
      send_command(CMD_INSERT, 40'h00_0000_0000, 32'h0000_0000);
      send_command(CMD_INSERT, 40'h80_1234_5678, 32'h8000_0000);
      send_command(CMD_INSERT, 40'h80_1234_5677, 32'haaaa_aaaa);
      send_command(CMD_INSERT, 40'h80_1234_5679, 32'h5555_5555);
      send_command(CMD_INSERT, 40'h80_1235_0000, 32'h0001_0000);
      send_command(CMD_INSERT, 40'h7f_ffff_ffff, 32'h0000_8000);
      send_command(CMD_LOOKUP, 40'h80_1234_5678, '1);
      send_command(CMD_LOOKUP, 40'h00_0000_0000, '0);
      send_command(CMD_LOOKUP, 40'hff_ffff_ffff, '0);
      send_command(CMD_LOOKUP, 40'h80_1234_5680, '0);
      send_command(CMD_LOOKUP, 40'h81_0000_0000, '0);
      send_command(CMD_INSERT, 40'hff_ffff_ffff, 32'h0000_0000);
      send_command(CMD_LOOKUP, 40'h00_0000_0001, 32'hdead_beef);
      send_command(CMD_INSERT, 40'h00_0000_0001, 32'h0000_0000);
      send_command(CMD_LOOKUP, 40'hfe_ffff_ffff, '0);
      drain_responses();

      // Random part; the table fills up in the middle and then refuses inserts.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps_on = !(i >= 100 && i < 250);
         if (i == 300) drain_responses();
         if (i == FILL_AT) begin
            while (table_model.entry_total < TABLE_DEPTH) begin
               send_command(CMD_INSERT, {8'($urandom()), 16'($urandom()), 16'($urandom())},
                            pick_mask());
            end
         end
         maybe_pause();
         send_command(($urandom_range(99) < (i < FILL_AT ? 25 : 50)) ? CMD_INSERT : CMD_LOOKUP,
                      pick_key(), pick_mask());
      end

      drain_responses();
      repeat (40) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

endmodule
